[rtl/core/ramr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ramr_pkg
// Shared width constants, state encoding and controller/datapath command and
// status types for the rational add/multiply/reduce block.
// ============================================================================
package ramr_pkg;

    localparam int unsigned WIDTH = 32;
    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    typedef logic [WIDTH-1:0] t_word;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_MUL = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM_START,
        S_PREP,
        S_GCD_TEST,
        S_GCD_DIV,
        S_DIVN_START,
        S_DIVN,
        S_DIVD_START,
        S_DIVD,
        S_NORM_DONE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;       // capture operands
        logic       sel_load;   // load working pair from slot (0=a,1=b,2=result)
        logic [1:0] slot;
        logic       prep;       // sign fix, gcd init
        logic       gcd_start;  // start divider on gcd pair
        logic       gcd_step;   // gcd pair <= (b, r)
        logic       divn_start; // divide n by g
        logic       divd_start; // divide d by g
        logic       latch_n;    // n <= quotient
        logic       latch_d;    // d <= quotient
        logic       zero_zero;  // set 0/0 and flag
        logic       store;      // write working pair back to slot
        logic       mul1;
        logic       mul2;
        logic       mul3;
        logic       emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic gcd_b_zero;
        logic gcd_a_zero;
    } t_stat;

endpackage

[rtl/core/ramr_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// ramr_div
// Iterative truncating signed divider, one quotient bit per cycle, with
// two's complement wrap on the most negative value.
// ============================================================================
module ramr_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ramr_pkg::t_word  i_a,
    input  ramr_pkg::t_word  i_b,
    output logic             o_done,
    output ramr_pkg::t_word  o_q,
    output ramr_pkg::t_word  o_r
);

    localparam int unsigned W = ramr_pkg::WIDTH;

    logic                        r_busy, n_busy;
    logic [ramr_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    ramr_pkg::t_word             r_q, n_q;
    ramr_pkg::t_word             r_rem, n_rem;
    ramr_pkg::t_word             r_div, n_div;
    logic                        r_qneg, n_qneg;
    logic                        r_rneg, n_rneg;
    logic                        r_done, n_done;
    logic [W:0]                  w_trial;
    ramr_pkg::t_word             w_ua, w_ub;

    assign w_ua    = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_ub    = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_trial = {r_rem, r_q[W-1]} - {1'b0, r_div};

    // shift-subtract restoring division on magnitudes
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = ramr_pkg::CNT_W'(W);
            n_q    = w_ua;
            n_rem  = '0;
            n_div  = w_ub;
            n_qneg = i_a[W-1] ^ i_b[W-1];
            n_rneg = i_a[W-1];
        end else if (r_busy) begin
            if (!w_trial[W]) begin
                n_rem = w_trial[W-1:0];
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-2:0], r_q[W-1]};
                n_q   = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ramr_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    assign o_done = r_done;
    assign o_q    = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_r    = r_rneg ? (~r_rem + 1'b1) : r_rem;

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    // done only after busy
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("done without busy");
    // busy is already clear whenever done is high
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("busy with done");

endmodule

[rtl/core/ramr_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// ramr_datapath
// Operand and result registers, normalize working pair, gcd pair, shared
// divider and a single 32x32 multiplier used in the three product steps.
// ============================================================================
module ramr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ramr_pkg::t_cmd   i_cmd,
    input  logic             i_op,
    input  logic [31:0]      i_a_num,
    input  logic [31:0]      i_a_den,
    input  logic [31:0]      i_b_num,
    input  logic [31:0]      i_b_den,
    output ramr_pkg::t_stat  o_stat,
    output logic             o_op_mul,
    output logic [31:0]      o_result_num,
    output logic [31:0]      o_result_den,
    output logic             o_zero_over_zero
);

    ramr_pkg::t_word r_an, r_ad, r_bn, r_bd, r_rn, r_rd;
    ramr_pkg::t_word r_n, r_d, r_ga, r_gb, r_p1, r_p2;
    logic            r_op, r_flag;
    logic            w_start;
    logic            w_div_done;
    ramr_pkg::t_word w_da, w_db, w_q, w_r, w_ma, w_mb, w_prod;
    ramr_pkg::t_word w_ln, w_ld, w_nabs;

    // divider operand select
    always_comb begin
        w_da = r_ga;
        w_db = r_gb;
        if (i_cmd.divn_start) begin
            w_da = r_n;
            w_db = r_ga;
        end else if (i_cmd.divd_start) begin
            w_da = r_d;
            w_db = r_ga;
        end
    end
    assign w_start = i_cmd.gcd_start | i_cmd.divn_start | i_cmd.divd_start;

    ramr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_da),
        .i_b     (w_db),
        .o_done  (w_div_done),
        .o_q     (w_q),
        .o_r     (w_r)
    );

    // multiplier operand select
    always_comb begin
        w_ma = r_ad;
        w_mb = r_bd;
        if (i_cmd.mul2) begin
            w_ma = r_an;
            w_mb = r_op ? r_bn : r_bd;
        end else if (i_cmd.mul3) begin
            w_ma = r_bn;
            w_mb = r_ad;
        end
    end
    assign w_prod = w_ma * w_mb;

    // working pair source
    always_comb begin
        case (i_cmd.slot)
            2'd0:    begin w_ln = r_an; w_ld = r_ad; end
            2'd1:    begin w_ln = r_bn; w_ld = r_bd; end
            default: begin w_ln = r_rn; w_ld = r_rd; end
        endcase
    end
    assign w_nabs = r_n[ramr_pkg::WIDTH-1] ? (~r_n + 1'b1) : r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cmd.load) begin
            r_flag <= 1'b0;
        end else if (i_cmd.zero_zero) begin
            r_flag <= 1'b1;
        end
        if (i_cmd.load) begin
            r_op <= i_op;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.sel_load) begin
            r_n <= w_ln;
            r_d <= w_ld;
        end
        // move sign of denominator, set up gcd pair
        if (i_cmd.prep) begin
            if (r_d[ramr_pkg::WIDTH-1]) begin
                r_n  <= ~r_n + 1'b1;
                r_d  <= ~r_d + 1'b1;
                r_ga <= w_nabs;
                r_gb <= ~r_d + 1'b1;
            end else begin
                r_ga <= w_nabs;
                r_gb <= r_d;
            end
        end
        if (i_cmd.gcd_step) begin
            r_ga <= r_gb;
            r_gb <= w_r;
        end
        if (i_cmd.latch_n) r_n <= w_q;
        if (i_cmd.latch_d) r_d <= w_q;
        if (i_cmd.zero_zero) begin
            r_n <= '0;
            r_d <= '0;
        end
        if (i_cmd.store) begin
            case (i_cmd.slot)
                2'd0:    begin r_an <= r_n; r_ad <= r_d; end
                2'd1:    begin r_bn <= r_n; r_bd <= r_d; end
                default: begin r_rn <= r_n; r_rd <= r_d; end
            endcase
        end
        if (i_cmd.mul1) r_p1 <= w_prod;
        if (i_cmd.mul2) r_p2 <= w_prod;
        if (i_cmd.mul3) begin
            r_rd <= r_p1;
            r_rn <= r_op ? r_p2 : (r_p2 + w_prod);
        end
    end

    assign o_stat.div_done   = w_div_done;
    assign o_stat.gcd_b_zero = (r_gb == '0);
    assign o_stat.gcd_a_zero = (r_ga == '0);
    assign o_op_mul          = r_op;
    assign o_result_num      = r_rn;
    assign o_result_den      = r_rd;
    assign o_zero_over_zero  = r_flag;

    // flag only rises on a 0/0 command
    a_flag_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flag) |-> $past(i_cmd.zero_zero)) else $error("flag without 0/0");
    // 0/0 clears working pair
    a_zz_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.zero_zero |=> (r_n == '0 && r_d == '0)) else $error("0/0 not cleared");
    // gcd division only starts with a nonzero divisor
    a_gcd_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gcd_start |-> !o_stat.gcd_b_zero) else $error("gcd divide by zero");

endmodule

[rtl/core/ramr_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// ramr_ctrl
// Sequencer: three normalizations (a, b, result) around the product step.
// ============================================================================
module ramr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ramr_pkg::t_stat  i_stat,
    output ramr_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    ramr_pkg::t_state r_state, n_state;
    logic [1:0]       r_slot, n_slot;

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        case (r_state)
            ramr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = ramr_pkg::S_NORM_START;
                    n_slot  = 2'd0;
                end
            end
            ramr_pkg::S_NORM_START: n_state = ramr_pkg::S_PREP;
            ramr_pkg::S_PREP: n_state = ramr_pkg::S_GCD_TEST;
            ramr_pkg::S_GCD_TEST: begin
                if (!i_stat.gcd_b_zero) n_state = ramr_pkg::S_GCD_DIV;
                else if (i_stat.gcd_a_zero) n_state = ramr_pkg::S_NORM_DONE;
                else n_state = ramr_pkg::S_DIVN_START;
            end
            ramr_pkg::S_GCD_DIV: if (i_stat.div_done) n_state = ramr_pkg::S_GCD_TEST;
            ramr_pkg::S_DIVN_START: n_state = ramr_pkg::S_DIVN;
            ramr_pkg::S_DIVN: if (i_stat.div_done) n_state = ramr_pkg::S_DIVD_START;
            ramr_pkg::S_DIVD_START: n_state = ramr_pkg::S_DIVD;
            ramr_pkg::S_DIVD: if (i_stat.div_done) n_state = ramr_pkg::S_NORM_DONE;
            ramr_pkg::S_NORM_DONE: begin
                if (r_slot == 2'd0) begin
                    n_slot  = 2'd1;
                    n_state = ramr_pkg::S_NORM_START;
                end else if (r_slot == 2'd1) begin
                    n_state = ramr_pkg::S_MUL1;
                end else begin
                    n_state = ramr_pkg::S_OUT;
                end
            end
            ramr_pkg::S_MUL1: n_state = ramr_pkg::S_MUL2;
            ramr_pkg::S_MUL2: n_state = ramr_pkg::S_MUL3;
            ramr_pkg::S_MUL3: begin
                n_slot  = 2'd2;
                n_state = ramr_pkg::S_NORM_START;
            end
            ramr_pkg::S_OUT: n_state = ramr_pkg::S_IDLE;
            default: n_state = ramr_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.slot = r_slot;
        o_busy     = (r_state != ramr_pkg::S_IDLE);
        o_done     = 1'b0;
        case (r_state)
            ramr_pkg::S_IDLE: o_cmd.load = i_start;
            ramr_pkg::S_NORM_START: o_cmd.sel_load = 1'b1;
            ramr_pkg::S_PREP: o_cmd.prep = 1'b1;
            ramr_pkg::S_GCD_TEST: begin
                if (!i_stat.gcd_b_zero) o_cmd.gcd_start = 1'b1;
                else if (i_stat.gcd_a_zero) o_cmd.zero_zero = 1'b1;
                else o_cmd.divn_start = 1'b1;
            end
            ramr_pkg::S_GCD_DIV: o_cmd.gcd_step = i_stat.div_done;
            ramr_pkg::S_DIVN: o_cmd.latch_n = i_stat.div_done;
            ramr_pkg::S_DIVD_START: o_cmd.divd_start = 1'b1;
            ramr_pkg::S_DIVD: o_cmd.latch_d = i_stat.div_done;
            ramr_pkg::S_NORM_DONE: o_cmd.store = 1'b1;
            ramr_pkg::S_MUL1: o_cmd.mul1 = 1'b1;
            ramr_pkg::S_MUL2: o_cmd.mul2 = 1'b1;
            ramr_pkg::S_MUL3: o_cmd.mul3 = 1'b1;
            ramr_pkg::S_OUT: begin
                o_cmd.emit = 1'b1;
                o_done     = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ramr_pkg::S_IDLE;
            r_slot  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // done follows the product step only through a result normalization
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_slot == 2'd2) else $error("done before result reduce");
    // slot never takes an unused code
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3) else $error("bad slot");
    // start in idle always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ramr_pkg::S_IDLE && i_start) |=>
        (r_state == ramr_pkg::S_NORM_START && o_busy))
        else $error("start ignored");

endmodule

[rtl/core/rational_add_multiply_reduce_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// rational_add_multiply_reduce_top
// Adds or multiplies two fractions and returns the reduced result.
// ============================================================================
// Pulse start while busy is low to launch a transaction. The result is
// shown on o_result_num/o_result_den/o_zero_over_zero for exactly one cycle
// with o_done high; the receiver cannot stall it and must take it then. One
// transaction runs at a time: three gcd reductions share one bit-serial
// divider. A reduction runs one division per gcd step plus two for the
// final divide, none on 0/0. Busy drops in the cycle after o_done, and
// the next transaction can be taken once busy is low.
module rational_add_multiply_reduce_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_done,
    output logic [31:0] o_result_num,
    output logic [31:0] o_result_den,
    output logic        o_zero_over_zero
);

    ramr_pkg::t_cmd  w_cmd;
    ramr_pkg::t_stat w_stat;
    logic            w_op_mul;

    ramr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ramr_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_opcode),
        .i_a_num          (i_a_num),
        .i_a_den          (i_a_den),
        .i_b_num          (i_b_num),
        .i_b_den          (i_b_den),
        .o_stat           (w_stat),
        .o_op_mul         (w_op_mul),
        .o_result_num     (o_result_num),
        .o_result_den     (o_result_den),
        .o_zero_over_zero (o_zero_over_zero)
    );

    // done only for a transaction whose operation was captured
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    // operation holds for the whole transaction
    a_op_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(w_op_mul)) else $error("op changed");
    // start is ignored while busy
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy) && !o_done) |=> busy) else $error("early idle");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for rational_add_multiply_reduce_top.
// ============================================================================
// A queue of fraction pairs feeds a clocked driver that launches each
// transaction with start/busy and idles at random. A clocked monitor compares
// every o_done strobe with the oldest predicted sum or product, computed here
// by a 32-bit rational arithmetic model with gcd reduction.
module tb_top;

    typedef struct {
        ramr_pkg::t_op op;
        logic [31:0]   an;
        logic [31:0]   ad;
        logic [31:0]   bn;
        logic [31:0]   bd;
    } t_frac_op;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        zz;
    } t_frac_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = 1'b0;
    logic [31:0] i_a_num = '0;
    logic [31:0] i_a_den = '0;
    logic [31:0] i_b_num = '0;
    logic [31:0] i_b_den = '0;
    logic        o_done;
    logic [31:0] o_result_num;
    logic [31:0] o_result_den;
    logic        o_zero_over_zero;

    t_frac_op     pending_ops[$];
    t_frac_result expected_fracs[$];
    int           launched = 0;
    int           total_ops = 0;
    int           errors = 0;
    longint       cycles = 0;
    bit           stim_done = 1'b0;

    rational_add_multiply_reduce_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_a_num          (i_a_num),
        .i_a_den          (i_a_den),
        .i_b_num          (i_b_num),
        .i_b_den          (i_b_den),
        .o_done           (o_done),
        .o_result_num     (o_result_num),
        .o_result_den     (o_result_den),
        .o_zero_over_zero (o_zero_over_zero)
    );

    always #5 i_clk = ~i_clk;

    // Truncating signed division at 32 bits; divisor is nonzero
    function automatic void sdivmod(input logic [31:0] a, input logic [31:0] b,
                                    output logic [31:0] q, output logic [31:0] r);
        logic [31:0] ua, ub, uq, ur;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        uq = ua / ub;
        ur = ua % ub;
        q = (a[31] != b[31]) ? -uq : uq;
        r = a[31] ? -ur : ur;
    endfunction

    function automatic logic [31:0] euclid_gcd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] q, r;
        while (b != 0) begin
            sdivmod(a, b, q, r);
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Move the sign to the numerator and divide out the gcd; 0/0 sets the flag
    function automatic void reduce_frac(inout logic [31:0] n, inout logic [31:0] d,
                                        inout logic zz);
        logic [31:0] g, q, r;
        if (d[31]) begin
            n = -n;
            d = -d;
        end
        g = euclid_gcd(n[31] ? -n : n, d);
        if (g == 0) begin
            zz = 1'b1;
            n = '0;
            d = '0;
        end else begin
            sdivmod(n, g, q, r);
            n = q;
            sdivmod(d, g, q, r);
            d = q;
        end
    endfunction

    function automatic t_frac_result compute_rational(input t_frac_op t);
        t_frac_result res;
        logic [31:0] an, ad, bn, bd;
        an = t.an; ad = t.ad; bn = t.bn; bd = t.bd;
        res.zz = 1'b0;
        reduce_frac(an, ad, res.zz);
        reduce_frac(bn, bd, res.zz);
        res.den = ad * bd;
        res.num = (t.op == ramr_pkg::OP_ADD) ? an * bd + bn * ad : an * bn;
        reduce_frac(res.num, res.den, res.zz);
        return res;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 40);
            2: return -$urandom_range(0, 40);
            3: return $urandom_range(0, 5000) * ($urandom_range(0, 1) ? 1 : -1);
            4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)} >>> $urandom_range(0, 31);
            default: return $urandom_range(1, 12) * $urandom_range(1, 12);
        endcase
    endfunction

    task automatic add_op(input ramr_pkg::t_op op, input logic [31:0] an,
                          input logic [31:0] ad, input logic [31:0] bn,
                          input logic [31:0] bd);
        t_frac_op t;
        t.op = op; t.an = an; t.ad = ad; t.bn = bn; t.bd = bd;
        pending_ops.push_back(t);
        total_ops++;
    endtask

    // Fill the stimulus: corner cases first, then random fraction pairs
    initial begin
        add_op(ramr_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        add_op(ramr_pkg::OP_MUL, 32'd2, 32'd3, 32'd9, 32'd4);
        add_op(ramr_pkg::OP_ADD, 32'd0, 32'd0, 32'd1, 32'd2);
        add_op(ramr_pkg::OP_MUL, 32'd3, 32'd4, 32'd0, 32'd0);
        add_op(ramr_pkg::OP_ADD, 32'd0, 32'd5, 32'd0, 32'd7);
        add_op(ramr_pkg::OP_MUL, 32'd5, 32'd0, 32'd7, 32'd0);
        add_op(ramr_pkg::OP_ADD, 32'd3, -32'd6, -32'd4, -32'd8);
        add_op(ramr_pkg::OP_MUL, -32'd3, -32'd6, 32'd4, -32'd8);
        add_op(ramr_pkg::OP_ADD, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        add_op(ramr_pkg::OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1);
        add_op(ramr_pkg::OP_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'd2);
        add_op(ramr_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF);
        add_op(ramr_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        add_op(ramr_pkg::OP_MUL, 32'h7FFF_FFFF, 32'd2, 32'h7FFF_FFFF, 32'd3);
        add_op(ramr_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        add_op(ramr_pkg::OP_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
        add_op(ramr_pkg::OP_ADD, 32'd1, 32'd2, -32'd1, 32'd2);
        add_op(ramr_pkg::OP_MUL, 32'h8000_0000, 32'd0, 32'd0, 32'h8000_0000);
        add_op(ramr_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'hFFFF_FFFF);
        add_op(ramr_pkg::OP_MUL, 32'd1346269, 32'd2178309, 32'd832040, 32'd1346269);
        for (int k = 0; k < 1500; k++) begin
            if ($urandom_range(0, 99) < 3)
                add_op(ramr_pkg::t_op'($urandom_range(0, 1)), 32'd0, 32'd0,
                       rand_part(), rand_part());
            else
                add_op(ramr_pkg::t_op'($urandom_range(0, 1)), rand_part(), rand_part(),
                       rand_part(), rand_part());
        end
        stim_done = 1'b1;
    end

    // Hold reset, then release it and wait for all results to drain
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_ops.size() == 0 && launched == total_ops);
        wait (expected_fracs.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_fracs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Driver: launch the head of the queue, idling at a phase-dependent rate
    always @(posedge i_clk) begin
        int idle_pct;
        bit go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_fracs.push_back(compute_rational(pending_ops.pop_front()));
                launched++;
            end
            idle_pct = (launched < total_ops / 3) ? 29 :
                       (launched < 2 * total_ops / 3) ? 62 : 0;
            go = pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct;
            start <= go;
            if (go) begin
                i_opcode <= pending_ops[0].op;
                i_a_num  <= pending_ops[0].an;
                i_a_den  <= pending_ops[0].ad;
                i_b_num  <= pending_ops[0].bn;
                i_b_den  <= pending_ops[0].bd;
            end
        end
    end

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_frac_result exp_r;
        if (i_rst_n && o_done) begin
            if (expected_fracs.size() == 0) begin
                $error("unexpected result %h/%h", o_result_num, o_result_den);
                errors++;
            end else begin
                exp_r = expected_fracs.pop_front();
                if (o_result_num !== exp_r.num) begin
                    $error("result_num expected %h actual %h", exp_r.num, o_result_num);
                    errors++;
                end
                if (o_result_den !== exp_r.den) begin
                    $error("result_den expected %h actual %h", exp_r.den, o_result_den);
                    errors++;
                end
                if (o_zero_over_zero !== exp_r.zz) begin
                    $error("zero_over_zero expected %b actual %b", exp_r.zz,
                           o_zero_over_zero);
                    errors++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 100_000_000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/core/ramr_pkg.sv
rtl/core/ramr_div.sv
rtl/core/ramr_datapath.sv
rtl/core/ramr_ctrl.sv
rtl/core/rational_add_multiply_reduce_top.sv
dv/tb_top.sv
